// ===== rtl/vsat_pkg.sv =====
// Shared constants, types and helpers for the volume summed-area table unit.
`timescale 1ns / 1ps
`default_nettype none

package vsat_pkg;

    localparam int EXT_W       = 9;   // extent register width
    localparam int VAL_W       = 16;  // Q0.16 channel value
    localparam int COL_W       = 24;  // depth column sum
    localparam int ROW_W       = 32;  // row running sum
    localparam int SUM_W       = 40;  // summed-area value
    localparam int NUM_PORT_CH = 4;   // channels on the ports
    localparam int CFG_IDX_W   = 2;

    localparam int DEF_MAX_EXTENT = 256;
    localparam int DEF_CHANNELS   = 4;

    localparam int MID_DEPTH = 4;     // front-to-back queue
    localparam int OUT_DEPTH = 8;     // result queue

    localparam logic [EXT_W-1:0] EXT_RESET = 9'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_DEPTH  = 2'd2
    } t_cfg_reg;

    // Per-voxel classification handed from front to back.
    typedef struct packed {
        logic x_first;
        logic y_first;
        logic z_first;
        logic last;
    } t_ctl;

    function automatic logic [EXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] v,
                                                      input logic [EXT_W-1:0] mx);
        logic [EXT_W-1:0] r;
        r = v;
        if (v == '0) r = EXT_W'(1);
        else if (v > mx) r = mx;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vsat_fifo.sv =====
// Small register queue with occupancy count.
`timescale 1ns / 1ps
`default_nettype none

module vsat_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    input  wire logic                       i_pop,
    output logic [WIDTH-1:0]                o_data,
    output logic                            o_empty,
    output logic                            o_full,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_count   = r_count;
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            if (w_do_pop)  r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            if (w_do_push && !w_do_pop)      r_count <= r_count + CNT_W'(1);
            else if (w_do_pop && !w_do_push) r_count <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

`default_nettype wire

// ===== rtl/vsat_front.sv =====
// Front end: extent registers, raster position tracking and voxel classification.
`timescale 1ns / 1ps
`default_nettype none

module vsat_front #(
    parameter int MAX_EXTENT = vsat_pkg::DEF_MAX_EXTENT,
    parameter int CHANNELS   = vsat_pkg::DEF_CHANNELS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [vsat_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [vsat_pkg::EXT_W-1:0]            i_cfg_data,
    input  wire logic                                  i_push,
    input  wire logic [CHANNELS*vsat_pkg::VAL_W-1:0]   i_vals,
    input  wire logic                                  i_q_full,
    output logic                                       o_q_push,
    output logic [CHANNELS*vsat_pkg::VAL_W-1:0]        o_q_vals,
    output logic [$clog2(MAX_EXTENT)-1:0]              o_q_x,
    output logic [$clog2(MAX_EXTENT)-1:0]              o_q_y,
    output vsat_pkg::t_ctl                             o_q_ctl
);

    localparam int CW    = $clog2(MAX_EXTENT);
    localparam int EXT_W = vsat_pkg::EXT_W;
    localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_EXTENT);

    logic [EXT_W-1:0] r_width;
    logic [EXT_W-1:0] r_height;
    logic [EXT_W-1:0] r_depth;
    logic [CW-1:0]    r_pos_x;
    logic [CW-1:0]    r_pos_y;
    logic [CW-1:0]    r_pos_z;
    logic [CW-1:0]    n_pos_x;
    logic [CW-1:0]    n_pos_y;
    logic [CW-1:0]    n_pos_z;

    logic [EXT_W-1:0] w_w;
    logic [EXT_W-1:0] w_h;
    logic [EXT_W-1:0] w_d;
    logic             w_x_last;
    logic             w_y_last;
    logic             w_z_last;
    logic             w_accept;

    assign w_w = vsat_pkg::clamp_extent(r_width,  MAX_EXT);
    assign w_h = vsat_pkg::clamp_extent(r_height, MAX_EXT);
    assign w_d = vsat_pkg::clamp_extent(r_depth,  MAX_EXT);

    assign w_x_last = (EXT_W'(r_pos_x) == w_w - EXT_W'(1));
    assign w_y_last = (EXT_W'(r_pos_y) == w_h - EXT_W'(1));
    assign w_z_last = (EXT_W'(r_pos_z) == w_d - EXT_W'(1));
    assign w_accept = i_push && !i_q_full;

    assign o_q_push         = w_accept;
    assign o_q_vals         = i_vals;
    assign o_q_x            = r_pos_x;
    assign o_q_y            = r_pos_y;
    assign o_q_ctl.x_first  = (r_pos_x == '0);
    assign o_q_ctl.y_first  = (r_pos_y == '0);
    assign o_q_ctl.z_first  = (r_pos_z == '0);
    assign o_q_ctl.last     = w_x_last && w_y_last && w_z_last;

    // advance in raster order, wrap at the end of the volume
    always_comb begin
        n_pos_x = r_pos_x + CW'(1);
        n_pos_y = r_pos_y;
        n_pos_z = r_pos_z;
        if (w_x_last) begin
            n_pos_x = '0;
            n_pos_y = r_pos_y + CW'(1);
            if (w_y_last) begin
                n_pos_y = '0;
                n_pos_z = w_z_last ? '0 : r_pos_z + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= vsat_pkg::EXT_RESET;
            r_height <= vsat_pkg::EXT_RESET;
            r_depth  <= vsat_pkg::EXT_RESET;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_pos_z  <= '0;
        end else if (i_cfg_we) begin
            // a write to a known register restarts the volume
            case (i_cfg_index)
                vsat_pkg::REG_WIDTH: begin
                    r_width <= i_cfg_data;
                    r_pos_x <= '0;
                    r_pos_y <= '0;
                    r_pos_z <= '0;
                end
                vsat_pkg::REG_HEIGHT: begin
                    r_height <= i_cfg_data;
                    r_pos_x  <= '0;
                    r_pos_y  <= '0;
                    r_pos_z  <= '0;
                end
                vsat_pkg::REG_DEPTH: begin
                    r_depth <= i_cfg_data;
                    r_pos_x <= '0;
                    r_pos_y <= '0;
                    r_pos_z <= '0;
                end
                default: begin
                end
            endcase
        end else if (w_accept) begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_pos_z <= n_pos_z;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vsat_back.sv =====
// Back end: column, row and plane accumulation pipeline with result queue.
`timescale 1ns / 1ps
`default_nettype none

module vsat_back #(
    parameter int MAX_EXTENT = vsat_pkg::DEF_MAX_EXTENT,
    parameter int CHANNELS   = vsat_pkg::DEF_CHANNELS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_q_empty,
    input  wire logic [CHANNELS*vsat_pkg::VAL_W-1:0]   i_q_vals,
    input  wire logic [$clog2(MAX_EXTENT)-1:0]         i_q_x,
    input  wire logic [$clog2(MAX_EXTENT)-1:0]         i_q_y,
    input  wire vsat_pkg::t_ctl                        i_q_ctl,
    output logic                                       o_q_pop,
    input  wire logic                                  i_out_pop,
    output logic                                       o_out_empty,
    output logic [CHANNELS*vsat_pkg::SUM_W-1:0]        o_out_sums,
    output logic                                       o_out_done
);

    localparam int CW     = $clog2(MAX_EXTENT);
    localparam int AW     = 2 * CW;
    localparam int VAL_W  = vsat_pkg::VAL_W;
    localparam int COL_W  = vsat_pkg::COL_W;
    localparam int ROW_W  = vsat_pkg::ROW_W;
    localparam int SUM_W  = vsat_pkg::SUM_W;
    localparam int ODEPTH = vsat_pkg::OUT_DEPTH;
    localparam int OCNT_W = $clog2(ODEPTH+1);
    localparam int OWIDTH = CHANNELS*SUM_W + 1;

    // column store: one entry per {y, x}, all channels side by side
    logic [CHANNELS*COL_W-1:0] r_col_mem  [2**AW];
    // previous-row plane sums: one entry per x
    logic [CHANNELS*SUM_W-1:0] r_prev_mem [MAX_EXTENT];

    // stage B: column sum
    logic                      r_b_valid;
    logic [CHANNELS*VAL_W-1:0] r_b_vals;
    logic [AW-1:0]             r_b_addr;
    logic [CW-1:0]             r_b_x;
    vsat_pkg::t_ctl            r_b_ctl;
    logic [CHANNELS*COL_W-1:0] r_col_rd;
    logic                      r_colf_valid;
    logic [AW-1:0]             r_colf_addr;
    logic [CHANNELS*COL_W-1:0] r_colf_data;
    logic [CHANNELS*COL_W-1:0] w_col_base;
    logic [CHANNELS*COL_W-1:0] w_colsum;

    // stage C: row running sum
    logic                      r_c_valid;
    logic [CHANNELS*COL_W-1:0] r_c_col;
    logic [CW-1:0]             r_c_x;
    vsat_pkg::t_ctl            r_c_ctl;
    logic [CHANNELS*ROW_W-1:0] r_rrs;
    logic [CHANNELS*ROW_W-1:0] w_rrs;

    // stage D: plane sum
    logic                      r_d_valid;
    logic [CHANNELS*ROW_W-1:0] r_d_rrs;
    logic [CW-1:0]             r_d_x;
    vsat_pkg::t_ctl            r_d_ctl;
    logic [CHANNELS*SUM_W-1:0] r_prev_rd;
    logic                      r_prvf_valid;
    logic [CW-1:0]             r_prvf_addr;
    logic [CHANNELS*SUM_W-1:0] r_prvf_data;
    logic [CHANNELS*SUM_W-1:0] w_prev_base;
    logic [CHANNELS*SUM_W-1:0] w_plane;

    logic [OCNT_W-1:0]         w_out_count;
    logic                      w_out_full;
    logic [OWIDTH-1:0]         w_out_data;
    logic [OCNT_W+1:0]         w_committed;

    // admit only when every word in flight still has a slot in the result queue
    assign w_committed = (OCNT_W+2)'(w_out_count) + (OCNT_W+2)'(r_b_valid)
                       + (OCNT_W+2)'(r_c_valid) + (OCNT_W+2)'(r_d_valid);
    assign o_q_pop = !i_q_empty && (w_committed < (OCNT_W+2)'(ODEPTH));

    // ---- column store: read at admit, write from stage B ----
    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_col_rd <= r_col_mem[{i_q_y, i_q_x}];
        if (r_b_valid) r_col_mem[r_b_addr] <= w_colsum;
    end

    // forward the write that raced the read
    assign w_col_base = (r_colf_valid && (r_colf_addr == r_b_addr)) ? r_colf_data : r_col_rd;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_colsum[c*COL_W +: COL_W] = r_b_ctl.z_first
                ? COL_W'(r_b_vals[c*VAL_W +: VAL_W])
                : w_col_base[c*COL_W +: COL_W] + COL_W'(r_b_vals[c*VAL_W +: VAL_W]);
        end
    end

    // ---- row running sum ----
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_rrs[c*ROW_W +: ROW_W] = (r_c_ctl.x_first ? '0 : r_rrs[c*ROW_W +: ROW_W])
                                    + ROW_W'(r_c_col[c*COL_W +: COL_W]);
        end
    end

    // ---- previous-row store: read from stage C, write from stage D ----
    always_ff @(posedge i_clk) begin
        if (r_c_valid) r_prev_rd <= r_prev_mem[r_c_x];
        if (r_d_valid) r_prev_mem[r_d_x] <= w_plane;
    end

    assign w_prev_base = (r_prvf_valid && (r_prvf_addr == r_d_x)) ? r_prvf_data : r_prev_rd;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_plane[c*SUM_W +: SUM_W] = r_d_ctl.y_first
                ? SUM_W'(r_d_rrs[c*ROW_W +: ROW_W])
                : w_prev_base[c*SUM_W +: SUM_W] + SUM_W'(r_d_rrs[c*ROW_W +: ROW_W]);
        end
    end

    // ---- pipeline control ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid    <= 1'b0;
            r_c_valid    <= 1'b0;
            r_d_valid    <= 1'b0;
            r_colf_valid <= 1'b0;
            r_prvf_valid <= 1'b0;
        end else begin
            r_b_valid    <= o_q_pop;
            r_c_valid    <= r_b_valid;
            r_d_valid    <= r_c_valid;
            r_colf_valid <= r_b_valid;
            r_prvf_valid <= r_d_valid;
        end
    end

    // ---- pipeline payload ----
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_b_vals <= i_q_vals;
            r_b_addr <= {i_q_y, i_q_x};
            r_b_x    <= i_q_x;
            r_b_ctl  <= i_q_ctl;
        end
        r_colf_addr <= r_b_addr;
        r_colf_data <= w_colsum;
        if (r_b_valid) begin
            r_c_col <= w_colsum;
            r_c_x   <= r_b_x;
            r_c_ctl <= r_b_ctl;
        end
        if (r_c_valid) begin
            r_rrs   <= w_rrs;
            r_d_rrs <= w_rrs;
            r_d_x   <= r_c_x;
            r_d_ctl <= r_c_ctl;
        end
        r_prvf_addr <= r_d_x;
        r_prvf_data <= w_plane;
    end

    vsat_fifo #(
        .WIDTH (OWIDTH),
        .DEPTH (ODEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_d_valid),
        .i_data  ({w_plane, r_d_ctl.last}),
        .i_pop   (i_out_pop),
        .o_data  (w_out_data),
        .o_empty (o_out_empty),
        .o_full  (w_out_full),
        .o_count (w_out_count)
    );

    assign o_out_sums = w_out_data[OWIDTH-1:1];
    assign o_out_done = w_out_data[0];

`ifndef NO_ASSERTIONS
    a_b_to_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |=> r_c_valid)
        else $error("word lost between column and row stages");

    a_c_to_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |=> r_d_valid)
        else $error("word lost between row and plane stages");

    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid |-> !w_out_full)
        else $error("result queue full when plane stage delivers");

    a_admit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (w_out_count != OCNT_W'(ODEPTH)))
        else $error("admitted word without a result slot");
`endif

endmodule

`default_nettype wire

// ===== rtl/volume_summed_area_table_unit.sv =====
// Top level of the streaming 3D summed-area table unit.
//
//  channel   direction  handshake            word
//  --------  ---------  -------------------  ------------------------------------------
//  voxel     in         push / full          i_red/green/blue/alpha_value (16b each)
//  result    out        empty / pop          o_red/green/blue/alpha_sum (40b), done
//  config    in         i_cfg_we (no wait)   i_cfg_index (2b), i_cfg_data (9b)
//
//  One voxel per cycle sustained while the result queue has room; a pushed voxel passes
//  the front queue, column stage, row stage and plane stage on its way to the result queue.
//  Both stores take one read and one write a cycle; a write that lands with a read
//  is forwarded. Reset sets the extents to 256 and clears positions and valid flags;
//  the stores are never cleared and are read only where written in the same volume.
//  A full result queue stops the back end; the front fills its own queue, then full.
`timescale 1ns / 1ps
`default_nettype none

module volume_summed_area_table_unit #(
    parameter int MAX_EXTENT = vsat_pkg::DEF_MAX_EXTENT,
    parameter int CHANNELS   = vsat_pkg::DEF_CHANNELS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [vsat_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [vsat_pkg::EXT_W-1:0]         i_cfg_data,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [vsat_pkg::VAL_W-1:0]         i_red_value,
    input  wire logic [vsat_pkg::VAL_W-1:0]         i_green_value,
    input  wire logic [vsat_pkg::VAL_W-1:0]         i_blue_value,
    input  wire logic [vsat_pkg::VAL_W-1:0]         i_alpha_value,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [vsat_pkg::SUM_W-1:0]              o_red_sum,
    output logic [vsat_pkg::SUM_W-1:0]              o_green_sum,
    output logic [vsat_pkg::SUM_W-1:0]              o_blue_sum,
    output logic [vsat_pkg::SUM_W-1:0]              o_alpha_sum,
    output logic                                    o_volume_done
);

    localparam int CW      = $clog2(MAX_EXTENT);
    localparam int VAL_W   = vsat_pkg::VAL_W;
    localparam int SUM_W   = vsat_pkg::SUM_W;
    localparam int PCH     = vsat_pkg::NUM_PORT_CH;
    localparam int CTL_W   = $bits(vsat_pkg::t_ctl);
    localparam int MID_W   = CHANNELS*VAL_W + 2*CW + CTL_W;

    logic [PCH*VAL_W-1:0]      w_in_flat;
    logic [PCH*SUM_W-1:0]      w_sum_flat;
    logic [CHANNELS*SUM_W-1:0] w_sum_vec;

    logic                      w_f_push;
    logic [CHANNELS*VAL_W-1:0] w_f_vals;
    logic [CW-1:0]             w_f_x;
    logic [CW-1:0]             w_f_y;
    vsat_pkg::t_ctl            w_f_ctl;

    logic [MID_W-1:0]          w_mid_out;
    logic                      w_mid_empty;
    logic                      w_mid_full;
    logic                      w_mid_pop;
    logic [$clog2(vsat_pkg::MID_DEPTH+1)-1:0] w_mid_count;

    logic [CHANNELS*VAL_W-1:0] w_b_vals;
    logic [CW-1:0]             w_b_x;
    logic [CW-1:0]             w_b_y;
    vsat_pkg::t_ctl            w_b_ctl;

    assign w_in_flat = {i_alpha_value, i_blue_value, i_green_value, i_red_value};
    assign full      = w_mid_full;

    vsat_front #(
        .MAX_EXTENT (MAX_EXTENT),
        .CHANNELS   (CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_vals      (w_in_flat[CHANNELS*VAL_W-1:0]),
        .i_q_full    (w_mid_full),
        .o_q_push    (w_f_push),
        .o_q_vals    (w_f_vals),
        .o_q_x       (w_f_x),
        .o_q_y       (w_f_y),
        .o_q_ctl     (w_f_ctl)
    );

    vsat_fifo #(
        .WIDTH (MID_W),
        .DEPTH (vsat_pkg::MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_push),
        .i_data  ({w_f_vals, w_f_y, w_f_x, w_f_ctl}),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_out),
        .o_empty (w_mid_empty),
        .o_full  (w_mid_full),
        .o_count (w_mid_count)
    );

    assign {w_b_vals, w_b_y, w_b_x, w_b_ctl} = w_mid_out;

    vsat_back #(
        .MAX_EXTENT (MAX_EXTENT),
        .CHANNELS   (CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_mid_empty),
        .i_q_vals    (w_b_vals),
        .i_q_x       (w_b_x),
        .i_q_y       (w_b_y),
        .i_q_ctl     (w_b_ctl),
        .o_q_pop     (w_mid_pop),
        .i_out_pop   (pop),
        .o_out_empty (empty),
        .o_out_sums  (w_sum_vec),
        .o_out_done  (o_volume_done)
    );

    // channels that are not kept read as zero
    assign w_sum_flat  = (PCH*SUM_W)'(w_sum_vec);
    assign o_red_sum   = w_sum_flat[0*SUM_W +: SUM_W];
    assign o_green_sum = w_sum_flat[1*SUM_W +: SUM_W];
    assign o_blue_sum  = w_sum_flat[2*SUM_W +: SUM_W];
    assign o_alpha_sum = w_sum_flat[3*SUM_W +: SUM_W];

`ifndef NO_ASSERTIONS
    a_mid_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_f_push |-> (w_mid_count != ($clog2(vsat_pkg::MID_DEPTH+1))'(vsat_pkg::MID_DEPTH)))
        else $error("front queue written while full");

    a_pop_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_pop |-> (w_mid_count != '0))
        else $error("back end took a word from an empty front queue");

    a_full_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mid_count == '0) |-> !full)
        else $error("full raised on an empty front queue");
`endif

endmodule

`default_nettype wire
